>>> rtl/bwlru_pkg.sv
// Package for the byte-weighted LRU cache: operation and status codes,
// controller command and datapath status structs. No dependencies.
`default_nettype none
package bwlru_pkg;
  localparam int unsigned ENTRY_SLOTS_DEF = 16;

  // Byte address of the capacity register on the APB port.
  localparam logic [2:0] ADDR_CAPACITY = 3'd0;

  localparam logic [2:0] OP_PUT      = 3'd0;
  localparam logic [2:0] OP_CONTAINS = 3'd1;
  localparam logic [2:0] OP_TOUCH    = 3'd2;
  localparam logic [2:0] OP_EVICT    = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REFRESH  = 2'd1;
  localparam logic [1:0] ST_TOOBIG   = 2'd2;
  localparam logic [1:0] ST_DONE     = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the input item
    logic scan_clr;   // restart a slot scan
    logic scan_step;  // examine one slot
    logic evict;      // evict the oldest slot found by the last scan
    logic refresh;    // refresh the found slot
    logic insert;     // age all and insert the new entry
    logic clear;      // empty the table
    logic done;       // present the result
    logic [1:0] status;
    logic hit_en;     // report hit from the lookup
  } bwlru_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // the current scan step is on the last slot
    logic found;      // key found by the scan
    logic any_valid;  // scan saw a valid slot
    logic full;       // all slots valid
    logic too_big;    // size exceeds capacity
    logic over_cap;   // occupied + size > capacity
    logic over_tgt;   // occupied > target
    logic [2:0] op;
  } bwlru_sts_t;
endpackage
`default_nettype wire

>>> rtl/bwlru_ctrl.sv
// Controller state machine of the byte-weighted LRU cache.
// Depends on bwlru_pkg.
`default_nettype none
module bwlru_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire bwlru_pkg::bwlru_sts_t sts,
  output bwlru_pkg::bwlru_cmd_t      cmd
);
  import bwlru_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_LOOK   = 8'b00000010,
    S_DECIDE = 8'b00000100,
    S_SCAN   = 8'b00001000,
    S_EVICT  = 8'b00010000,
    S_FULL   = 8'b00100000,
    S_INS    = 8'b01000000,
    S_CHK    = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic full_evict_r, full_evict_nxt;

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      full_evict_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      full_evict_r <= full_evict_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt      = state_r;
    full_evict_nxt = full_evict_r;
    cmd            = '0;
    cmd.status     = ST_DONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.scan_clr = 1'b1;
        state_nxt    = S_IDLE;
        cmd.done     = 1'b1;
        case (sts.op)
          OP_PUT: begin
            cmd.hit_en = 1'b1;
            if (sts.too_big) begin
              cmd.status = ST_TOOBIG;
            end else if (sts.found) begin
              cmd.refresh = 1'b1;
              cmd.status  = ST_REFRESH;
            end else begin
              cmd.done  = 1'b0;
              state_nxt = sts.over_cap ? S_SCAN : S_FULL;
            end
          end
          OP_CONTAINS: cmd.hit_en = 1'b1;
          OP_TOUCH: begin
            cmd.hit_en  = 1'b1;
            cmd.refresh = sts.found;
          end
          OP_EVICT: begin
            if (sts.over_tgt) begin
              cmd.done  = 1'b0;
              state_nxt = S_SCAN;
            end
          end
          OP_CLEAR: cmd.clear = 1'b1;
          default: ;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_EVICT;
      end
      S_EVICT: begin
        // Evict the oldest slot if one exists; occupancy settles next cycle.
        cmd.evict    = sts.any_valid;
        cmd.scan_clr = 1'b1;
        if (full_evict_r) begin
          full_evict_nxt = 1'b0;
          state_nxt      = S_INS;
        end else if (sts.any_valid) begin
          state_nxt = S_CHK;
        end else if (sts.op == OP_PUT) begin
          state_nxt = S_FULL;
        end else begin
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CHK: begin
        // Compare the updated occupancy against the byte limit again.
        cmd.scan_clr = 1'b1;
        if (sts.op == OP_PUT) begin
          state_nxt = sts.over_cap ? S_SCAN : S_FULL;
        end else if (sts.over_tgt) begin
          state_nxt = S_SCAN;
        end else begin
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FULL: begin
        cmd.scan_clr = 1'b1;
        if (sts.full) begin
          full_evict_nxt = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        cmd.insert = 1'b1;
        cmd.done   = 1'b1;
        cmd.hit_en = 1'b1;
        cmd.status = ST_INSERTED;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/bwlru_dp.sv
// Datapath of the byte-weighted LRU cache: slot tables, scan pointer,
// occupancy counter and result registers. Depends on bwlru_pkg.
`default_nettype none
module bwlru_dp #(
  parameter int unsigned SLOTS = bwlru_pkg::ENTRY_SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [2:0]            in_op,
  input  wire logic [31:0]           in_key,
  input  wire logic [31:0]           in_size_bytes,
  input  wire logic [31:0]           in_target_bytes,
  input  wire logic [31:0]           capacity,
  input  wire bwlru_pkg::bwlru_cmd_t cmd,
  output bwlru_pkg::bwlru_sts_t      sts,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic [1:0]                 out_status,
  output logic [31:0]                out_used_bytes,
  output logic [4:0]                 out_evicted_count
);
  import bwlru_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  logic [2:0]  op_r;
  logic [31:0] key_r, size_r, tgt_r;
  logic [SLOTS-1:0] valid_r;
  logic [31:0] key_mem [SLOTS];
  logic [31:0] size_mem [SLOTS];
  logic [IW-1:0] age_r [SLOTS];
  logic [31:0] occ_r;
  logic [IW-1:0] ptr_r;
  logic [IW-1:0] best_r;
  logic [IW-1:0] fnd_r;
  logic best_v_r;
  logic found_r;
  logic [4:0] ev_r;
  logic [CW-1:0] cnt;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] ref_age;
  logic last;

  assign last = (ptr_r == IW'(SLOTS - 1));

  // Population count and first free slot.
  always_comb begin
    cnt      = '0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (valid_r[i]) cnt = cnt + CW'(1);
      else free_idx = IW'(i);
    end
  end

  assign ref_age = age_r[fnd_r];

  assign sts.scan_last = last;
  assign sts.found     = found_r;
  assign sts.any_valid = best_v_r;
  assign sts.full      = (cnt == CW'(SLOTS));
  assign sts.too_big   = (size_r > capacity);
  assign sts.over_cap  = ({1'b0, occ_r} + {1'b0, size_r}) > {1'b0, capacity};
  assign sts.over_tgt  = (occ_r > tgt_r);
  assign sts.op        = op_r;

  // Control state: valid bits, scan, occupancy, ages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      occ_r     <= '0;
      ptr_r     <= '0;
      best_v_r  <= 1'b0;
      found_r   <= 1'b0;
      ev_r      <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.done;
      if (cmd.load) ev_r <= '0;
      if (cmd.scan_clr) begin
        ptr_r    <= '0;
        best_v_r <= 1'b0;
        if (cmd.load) found_r <= 1'b0;
      end else if (cmd.scan_step) begin
        ptr_r <= last ? ptr_r : ptr_r + IW'(1);
        // The key match and the oldest valid slot are tracked side by side.
        if (valid_r[ptr_r]) begin
          if (key_mem[ptr_r] == key_r && !found_r) begin
            found_r <= 1'b1;
            fnd_r   <= ptr_r;
          end
          if (!best_v_r || age_r[ptr_r] > age_r[best_r]) begin
            best_v_r <= 1'b1;
            best_r   <= ptr_r;
          end
        end
      end
      if (cmd.evict) begin
        valid_r[best_r] <= 1'b0;
        occ_r <= occ_r - size_mem[best_r];
        if (ev_r != 5'd31) ev_r <= ev_r + 5'd1;
      end
      if (cmd.refresh) begin
        for (int i = 0; i < SLOTS; i++)
          if (valid_r[i] && age_r[i] < ref_age) age_r[i] <= age_r[i] + IW'(1);
        age_r[fnd_r] <= '0;
      end
      if (cmd.insert) begin
        for (int i = 0; i < SLOTS; i++)
          if (valid_r[i]) age_r[i] <= age_r[i] + IW'(1);
        valid_r[free_idx] <= 1'b1;
        age_r[free_idx]   <= '0;
        occ_r <= occ_r + size_r;
      end
      if (cmd.clear) begin
        valid_r <= '0;
        occ_r   <= '0;
        // The count saturates at the width of the result field.
        ev_r    <= (32'(cnt) > 32'd31) ? 5'd31 : 5'(cnt);
      end
    end
  end

  // Input latch and entry payload stores.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      key_r <= in_key;
      size_r <= in_size_bytes;
      tgt_r <= in_target_bytes;
    end
    if (cmd.insert) begin
      key_mem[free_idx]  <= key_r;
      size_mem[free_idx] <= size_r;
    end
  end

  // Result registers, valid in the cycle after done.
  always_ff @(posedge clk) begin
    if (cmd.done) begin
      out_hit    <= cmd.hit_en & found_r;
      out_status <= cmd.status;
    end
  end

  assign out_used_bytes    = occ_r;
  assign out_evicted_count = ev_r;
endmodule
`default_nettype wire

>>> rtl/byte_weighted_lru_cache.sv
// Top level of the byte-weighted LRU cache: APB register, controller and
// datapath. Depends on bwlru_pkg, bwlru_ctrl and bwlru_dp.
//
// Usage: drive in_op, in_key, in_size_bytes and in_target_bytes with
// start high while busy is low; the item is taken at that edge. Each item
// gives one result, shown on the out_ ports for one cycle with out_valid
// high. A lookup scan walks the slots one per cycle and a decide state
// follows; each eviction takes a further scan and an evict state, then a
// recheck state, except the eviction that frees a slot for an insert.
// A put that inserts passes a full-slot check and an insert state after
// its evictions, with a further eviction first when every slot is taken.
// busy drops in the cycle the result shows, so the next item may be taken
// then. The slot scan sets the rate; one item is in work at a time.
// The receiver cannot stall: the result must be taken when it shows.
// capacity_bytes lies at address 0 of the APB port, written while idle.
// Synchronous reset empties the table and clears capacity to zero.
`default_nettype none
module byte_weighted_lru_cache #(
  parameter int unsigned ENTRY_SLOTS = bwlru_pkg::ENTRY_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_op,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_size_bytes,
  input  wire logic [31:0] in_target_bytes,
  output logic             out_valid,
  output logic             out_hit,
  output logic [1:0]       out_status,
  output logic [31:0]      out_used_bytes,
  output logic [4:0]       out_evicted_count,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bwlru_pkg::*;

  logic [31:0] cap_r;
  bwlru_cmd_t cmd;
  bwlru_sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CAPACITY) ? cap_r : 32'd0;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
    end else if (psel && penable && pwrite && paddr == ADDR_CAPACITY) begin
      cap_r <= pwdata;
    end
  end

  bwlru_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  bwlru_dp #(.SLOTS(ENTRY_SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_op(in_op), .in_key(in_key),
    .in_size_bytes(in_size_bytes), .in_target_bytes(in_target_bytes),
    .capacity(cap_r), .cmd(cmd), .sts(sts), .out_valid(out_valid),
    .out_hit(out_hit), .out_status(out_status), .out_used_bytes(out_used_bytes),
    .out_evicted_count(out_evicted_count)
  );
endmodule
`default_nettype wire

>>> dv/tb_byte_weighted_lru_cache.sv
// Self-checking testbench for the byte-weighted LRU cache: drives command
// items and APB capacity writes, and checks every result against a predictor.
// Depends on bwlru_pkg and the byte_weighted_lru_cache RTL.
module tb_byte_weighted_lru_cache;
  timeunit 1ns;
  timeprecision 1ps;
  import bwlru_pkg::*;

  localparam int SLOTS = 16;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic        hit;
    logic [1:0]  status;
    logic [31:0] used;
    logic [4:0]  evicted;
  } cache_result_t;

  // One row of the directed table; chk marks a typed-in expected result.
  typedef struct {
    logic [2:0]    op;
    logic [31:0]   key;
    logic [31:0]   size;
    logic [31:0]   target;
    bit            chk;
    cache_result_t res;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_op = '0;
  logic [31:0] in_key = '0;
  logic [31:0] in_size_bytes = '0;
  logic [31:0] in_target_bytes = '0;
  logic        out_valid;
  logic        out_hit;
  logic [1:0]  out_status;
  logic [31:0] out_used_bytes;
  logic [4:0]  out_evicted_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  byte_weighted_lru_cache u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_key(in_key), .in_size_bytes(in_size_bytes),
    .in_target_bytes(in_target_bytes),
    .out_valid(out_valid), .out_hit(out_hit), .out_status(out_status),
    .out_used_bytes(out_used_bytes), .out_evicted_count(out_evicted_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predicted cache contents.
  bit          lru_valid [SLOTS];
  logic [31:0] lru_key [SLOTS];
  logic [31:0] lru_size [SLOTS];
  int          lru_age [SLOTS];
  logic [31:0] lru_used;
  logic [31:0] lru_capacity;

  cache_result_t pending_results[$];
  int  fail_count = 0;
  longint cycle_count = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Global watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Compare every result with the oldest expectation.
  always @(posedge clk) begin
    cache_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting");
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_hit !== exp_res.hit) begin
          $error("hit: expected %0d actual %0d", exp_res.hit, out_hit);
          fail_count++;
        end
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d actual %0d", exp_res.status, out_status);
          fail_count++;
        end
        if (out_used_bytes !== exp_res.used) begin
          $error("used_bytes: expected %0d actual %0d", exp_res.used, out_used_bytes);
          fail_count++;
        end
        if (out_evicted_count !== exp_res.evicted) begin
          $error("evicted_count: expected %0d actual %0d",
                 exp_res.evicted, out_evicted_count);
          fail_count++;
        end
      end
    end
  end

  function automatic int find_slot(logic [31:0] k);
    for (int i = 0; i < SLOTS; i++)
      if (lru_valid[i] && lru_key[i] == k) return i;
    return -1;
  endfunction

  // Remove the least recent entry; returns 0 when the table is empty.
  function automatic bit drop_oldest();
    int best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (lru_valid[i] && (best < 0 || lru_age[i] > lru_age[best])) best = i;
    if (best < 0) return 0;
    lru_used -= lru_size[best];
    lru_valid[best] = 0;
    return 1;
  endfunction

  function automatic void make_recent(int s);
    int a = lru_age[s];
    for (int i = 0; i < SLOTS; i++)
      if (lru_valid[i] && lru_age[i] < a) lru_age[i]++;
    lru_age[s] = 0;
  endfunction

  // Predict one item's result and update the predicted contents.
  function automatic cache_result_t predict_cache_op(logic [2:0] op, logic [31:0] k,
                                                     logic [31:0] sz, logic [31:0] tgt);
    cache_result_t r;
    int s = find_slot(k);
    int evicted = 0;
    int n = 0;
    int free_slot = -1;
    r.hit = 1'b0;
    r.status = ST_DONE;
    case (op)
      OP_PUT: begin
        r.hit = (s >= 0);
        if (sz > lru_capacity) begin
          r.status = ST_TOOBIG;
        end else if (s >= 0) begin
          make_recent(s);
          r.status = ST_REFRESH;
        end else begin
          while ({1'b0, lru_used} + {1'b0, sz} > {1'b0, lru_capacity}) begin
            if (!drop_oldest()) break;
            evicted++;
          end
          for (int i = 0; i < SLOTS; i++) if (lru_valid[i]) n++;
          if (n >= SLOTS) begin
            void'(drop_oldest());
            evicted++;
          end
          for (int i = 0; i < SLOTS; i++) begin
            if (lru_valid[i]) lru_age[i]++;
            else if (free_slot < 0) free_slot = i;
          end
          if (free_slot >= 0) begin
            lru_valid[free_slot] = 1;
            lru_key[free_slot] = k;
            lru_size[free_slot] = sz;
            lru_age[free_slot] = 0;
            lru_used += sz;
          end
          r.status = ST_INSERTED;
        end
      end
      OP_CONTAINS: r.hit = (s >= 0);
      OP_TOUCH: begin
        r.hit = (s >= 0);
        if (s >= 0) make_recent(s);
      end
      OP_EVICT: begin
        while (lru_used > tgt) begin
          if (!drop_oldest()) break;
          evicted++;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) if (lru_valid[i]) evicted++;
        for (int i = 0; i < SLOTS; i++) lru_valid[i] = 0;
        lru_used = '0;
      end
      default: ;
    endcase
    r.used = lru_used;
    r.evicted = (evicted > 31) ? 5'd31 : evicted[4:0];
    return r;
  endfunction

  // Random gap: mostly none or short, now and then long.
  task automatic idle_gap();
    int pick = $urandom_range(0, 99);
    if (pick < 40) return;
    if (pick < 90) repeat ($urandom_range(1, 4)) @(negedge clk);
    else repeat ($urandom_range(10, 60)) @(negedge clk);
  endtask

  // Send one item and queue its expectation; a typed-in result is
  // cross-checked against the predictor.
  task automatic send_item(logic [2:0] op, logic [31:0] k, logic [31:0] sz,
                           logic [31:0] tgt, bit chk, cache_result_t typed);
    cache_result_t r;
    start <= 1'b1;
    in_op <= op;
    in_key <= k;
    in_size_bytes <= sz;
    in_target_bytes <= tgt;
    do @(posedge clk); while (busy);
    r = predict_cache_op(op, k, sz, tgt);
    if (chk && r !== typed) begin
      $error("directed row op %0d: expected %h predicted %h", op, typed, r);
      fail_count++;
    end
    pending_results.push_back(chk ? typed : r);
    @(negedge clk);
    start <= 1'b0;
    // The block stays busy through the slot scan, so this costs no throughput.
    @(negedge clk);
  endtask

  // Write capacity while idle, after the in-flight work has drained.
  task automatic write_capacity(logic [31:0] value);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SLOTS * 40) @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_CAPACITY;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    lru_capacity = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic cache_result_t mk(logic h, logic [1:0] st, logic [31:0] u,
                                       logic [4:0] e);
    mk.hit = h;
    mk.status = st;
    mk.used = u;
    mk.evicted = e;
  endfunction

  // Random item from a small key pool so that hits and evictions happen.
  task automatic random_item(logic [31:0] key_base);
    logic [2:0]  op;
    logic [31:0] k, sz, tgt;
    int pick = $urandom_range(0, 99);
    if (pick < 50) op = OP_PUT;
    else if (pick < 65) op = OP_CONTAINS;
    else if (pick < 80) op = OP_TOUCH;
    else if (pick < 92) op = OP_EVICT;
    else if (pick < 96) op = OP_CLEAR;
    else op = 3'($urandom_range(5, 7));
    k = ($urandom_range(0, 9) == 0) ? $urandom() : key_base + $urandom_range(0, 23);
    pick = $urandom_range(0, 9);
    if (pick < 6) sz = $urandom_range(0, (lru_capacity >> 3) + 1);
    else if (pick < 8) sz = $urandom_range(0, lru_capacity > 64'hFFFF ? 32'hFFFF
                                                                 : lru_capacity);
    else sz = $urandom();
    tgt = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, lru_used);
    send_item(op, k, sz, tgt, 1'b0, '0);
  endtask

  directed_row_t directed[$];
  logic [31:0] caps[6];

  initial begin
    cache_result_t none;
    none = '0;
    caps[0] = 32'd1000;
    caps[1] = 32'hFFFF_FFFF;
    caps[2] = 32'd0;
    caps[3] = 32'd64;
    caps[4] = 32'd100000;
    caps[5] = 32'h8000_0000;
    for (int i = 0; i < SLOTS; i++) lru_valid[i] = 0;
    lru_used = '0;
    lru_capacity = '0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // After reset capacity is zero: any nonzero put is too big.
    directed.push_back('{OP_PUT, 32'h1, 32'd1, 32'd0, 1'b1,
                         mk(1'b0, ST_TOOBIG, 32'd0, 5'd0)});
    directed.push_back('{OP_PUT, 32'h0, 32'd0, 32'd0, 1'b1,
                         mk(1'b0, ST_INSERTED, 32'd0, 5'd0)});
    directed.push_back('{OP_CONTAINS, 32'h0, 32'd0, 32'd0, 1'b1,
                         mk(1'b1, ST_DONE, 32'd0, 5'd0)});
    directed.push_back('{3'd7, 32'h0, 32'd0, 32'd0, 1'b1,
                         mk(1'b0, ST_DONE, 32'd0, 5'd0)});
    directed.push_back('{OP_CLEAR, 32'h0, 32'd0, 32'd0, 1'b1,
                         mk(1'b0, ST_DONE, 32'd0, 5'd1)});
    foreach (directed[i])
      send_item(directed[i].op, directed[i].key, directed[i].size, directed[i].target,
                directed[i].chk, directed[i].res);

    // Extremes, full slots, present-key refresh and evict-until.
    write_capacity(32'hFFFF_FFFF);
    directed.delete();
    directed.push_back('{OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1,
                         mk(1'b0, ST_INSERTED, 32'hFFFF_FFFF, 5'd0)});
    directed.push_back('{OP_PUT, 32'hFFFF_FFFF, 32'd5, 32'd0, 1'b1,
                         mk(1'b1, ST_REFRESH, 32'hFFFF_FFFF, 5'd0)});
    directed.push_back('{OP_PUT, 32'h5, 32'd1, 32'd0, 1'b1,
                         mk(1'b0, ST_INSERTED, 32'd1, 5'd1)});
    for (int i = 0; i < 17; i++)
      directed.push_back('{OP_PUT, 32'h100 + i, 32'd2, 32'd0, 1'b0, none});
    directed.push_back('{OP_TOUCH, 32'h101, 32'd0, 32'd0, 1'b0, none});
    directed.push_back('{OP_EVICT, 32'd0, 32'd0, 32'd4, 1'b0, none});
    directed.push_back('{OP_EVICT, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, none});
    directed.push_back('{OP_CLEAR, 32'd0, 32'd0, 32'd0, 1'b0, none});
    foreach (directed[i])
      send_item(directed[i].op, directed[i].key, directed[i].size, directed[i].target,
                directed[i].chk, directed[i].res);

    // Random phases across several capacities.
    foreach (caps[c]) begin
      write_capacity(caps[c]);
      for (int n = 0; n < 75; n++) begin
        idle_gap();
        random_item(32'h1000 * c);
      end
    end
    write_capacity($urandom());

    while (pending_results.size() != 0) @(negedge clk);
    repeat (SLOTS * 40) @(negedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
